/* hdl/gha_pkg.sv */
package gha_pkg;

   localparam int TYPE_W  = 2;
   localparam int INDEX_W = 10;
   localparam int GEN_W   = 16;
   localparam int COUNT_W = 11;
   localparam int STAT_W  = 2;

   localparam logic [TYPE_W-1:0] REQ_ALLOC    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FREE     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_VALIDATE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_CAP   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_STALE = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [INDEX_W-1:0] slot_index;
      logic [GEN_W-1:0]   slot_generation;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] out_index;
      logic [GEN_W-1:0]   out_generation;
      logic [COUNT_W-1:0] live_count;
   } rsp_payload_type;

endpackage

/* hdl/generational_handle_allocator.sv */
// Channel    | Direction | Handshake             | Payload
// req_*      | in        | req_valid / req_stall | gha_pkg::req_payload_type
// rsp_*      | out       | rsp_valid / rsp_stall | gha_pkg::rsp_payload_type
// csr_*      | in        | csr_valid / csr_ready | soft cap, 11 bits
//
// For each request the slot memory is read at the accepting edge and written
// back at the edge that loads the response register; no new request is taken
// in between. The single-port slot memory read-modify-write sets this order.
// Reset is synchronous; no clearing pass is needed, since slots at or above
// the used-slot count read as never used.
// A stalled response holds the write-back until the response register frees.
module generational_handle_allocator #(
   parameter int SLOTS    = 1024,
   parameter int GEN_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  gha_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gha_pkg::rsp_payload_type             rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gha_pkg::COUNT_W-1:0]          csr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int LW    = $clog2(SLOTS + 1);
   localparam int CW    = (LW > gha_pkg::COUNT_W) ? LW : gha_pkg::COUNT_W;

   localparam logic [CW-1:0]       SLOTS_C    = CW'(SLOTS);
   localparam logic [LW-1:0]       HEAD_EMPTY = LW'(SLOTS);
   localparam logic [GEN_BITS-1:0] GEN_ONE    = GEN_BITS'(1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic                alive;
      logic [GEN_BITS-1:0] gen;
      logic [LW-1:0]       link;
   } entry_type;

   entry_type mem [SLOTS];

   state_type                      state_ff, state_in;
   gha_pkg::req_payload_type       req_ff, req_in;
   logic [IDX_W-1:0]               addr_ff, addr_in;
   logic                           ent_ok_ff, ent_ok_in;
   logic                           in_range_ff, in_range_in;
   logic [LW-1:0]                  head_ff, head_in;
   logic [LW-1:0]                  used_ff, used_in;
   logic [LW-1:0]                  live_ff, live_in;
   logic [gha_pkg::COUNT_W-1:0]    cap_ff, cap_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   gha_pkg::rsp_payload_type       rsp_ff, rsp_in;
   entry_type                      rd_data_ff;

   logic                           accept;
   logic                           done;
   logic [IDX_W-1:0]               rd_addr;
   entry_type                      ent;
   entry_type                      wr_data;
   logic                           wr_en;
   logic                           hit;
   logic                           cap_hit;
   logic [GEN_BITS-1:0]            gen_bump;
   logic [GEN_BITS-1:0]            gen_alloc;
   logic [LW-1:0]                  link_next;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (req_data.req_type == gha_pkg::REQ_ALLOC) begin
         rd_addr = (head_ff != HEAD_EMPTY) ? head_ff[IDX_W-1:0] : used_ff[IDX_W-1:0];
      end else begin
         rd_addr = IDX_W'(req_data.slot_index);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
   end

   assign ent       = ent_ok_ff ? rd_data_ff : '0;
   assign done      = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign hit       = in_range_ff && ent.alive &&
                      (ent.gen == GEN_BITS'(req_ff.slot_generation));
   assign cap_hit   = (cap_ff != '0) && (CW'(live_ff) >= CW'(cap_ff));
   assign gen_bump  = ((ent.gen + GEN_ONE) == '0) ? GEN_ONE : (ent.gen + GEN_ONE);
   assign gen_alloc = (ent.gen == '0) ? GEN_ONE : ent.gen;
   assign link_next = (CW'(ent.link) < SLOTS_C) ? ent.link : HEAD_EMPTY;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      ent_ok_in    = ent_ok_ff;
      in_range_in  = in_range_ff;
      head_in      = head_ff;
      used_in      = used_ff;
      live_in      = live_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = ent;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      if (accept) begin
         state_in    = S_EXEC;
         req_in      = req_data;
         addr_in     = rd_addr;
         ent_ok_in   = (CW'(rd_addr) < CW'(used_ff));
         in_range_in = (CW'(req_data.slot_index) < SLOTS_C);
      end

      if (done) begin
         state_in              = S_IDLE;
         rsp_valid_in          = 1'b1;
         rsp_in.status         = gha_pkg::ST_STALE;
         rsp_in.out_index      = '0;
         rsp_in.out_generation = '0;
         unique case (req_ff.req_type)
            gha_pkg::REQ_ALLOC: begin
               if (cap_hit) begin
                  rsp_in.status = gha_pkg::ST_CAP;
               end else if (head_ff != HEAD_EMPTY || CW'(used_ff) < SLOTS_C) begin
                  if (head_ff != HEAD_EMPTY) begin
                     head_in = link_next;
                  end else begin
                     used_in = used_ff + LW'(1);
                  end
                  wr_en                 = 1'b1;
                  wr_data.alive         = 1'b1;
                  wr_data.gen           = gen_alloc;
                  live_in               = live_ff + LW'(1);
                  rsp_in.status         = gha_pkg::ST_OK;
                  rsp_in.out_index      = gha_pkg::INDEX_W'(addr_ff);
                  rsp_in.out_generation = gha_pkg::GEN_W'(gen_alloc);
               end else begin
                  rsp_in.status = gha_pkg::ST_FULL;
               end
            end
            gha_pkg::REQ_FREE: begin
               if (hit) begin
                  wr_en         = 1'b1;
                  wr_data.alive = 1'b0;
                  wr_data.gen   = gen_bump;
                  wr_data.link  = head_ff;
                  head_in       = LW'(addr_ff);
                  live_in       = live_ff - LW'(1);
                  rsp_in.status = gha_pkg::ST_OK;
               end
            end
            gha_pkg::REQ_VALIDATE: begin
               if (hit) begin
                  rsp_in.status = gha_pkg::ST_OK;
               end
            end
            default: begin
               rsp_in.status = gha_pkg::ST_STALE;
            end
         endcase
         rsp_in.live_count = gha_pkg::COUNT_W'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= HEAD_EMPTY;
         used_ff      <= '0;
         live_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      addr_ff     <= addr_in;
      ent_ok_ff   <= ent_ok_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

endmodule

/* hdl/gha_checker.sv */
module gha_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input gha_pkg::rsp_payload_type    rsp_data
);

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Only one request transaction is in flight at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // A failed request never reports a handle.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != gha_pkg::ST_OK |->
         rsp_data.out_index == '0 && rsp_data.out_generation == '0)
      else $error("failed response carries a handle");

   // A new response only follows an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without request");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* sim/generational_handle_allocator_tb.sv */
module generational_handle_allocator_tb;

   localparam int SLOT_COUNT = 1024;
   localparam logic [gha_pkg::COUNT_W-1:0] LIST_END = gha_pkg::COUNT_W'(SLOT_COUNT);
   localparam logic [gha_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      logic [gha_pkg::INDEX_W-1:0] idx;
      logic [gha_pkg::GEN_W-1:0]   gen;
   } handle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gha_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gha_pkg::rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gha_pkg::COUNT_W-1:0] csr_data = '0;

   // Shadow copy of the allocator state.
   logic [gha_pkg::GEN_W-1:0]   slot_gen [SLOT_COUNT];
   logic                        slot_live [SLOT_COUNT];
   logic [gha_pkg::COUNT_W-1:0] slot_link [SLOT_COUNT];
   logic [gha_pkg::COUNT_W-1:0] free_head = LIST_END;
   logic [gha_pkg::COUNT_W-1:0] used_slots = '0;
   logic [gha_pkg::COUNT_W-1:0] live_total = '0;
   logic [gha_pkg::COUNT_W-1:0] soft_cap = '0;

   handle_type               live_handles [$];
   gha_pkg::req_payload_type pending_reqs [$];
   gha_pkg::rsp_payload_type expected_rsps [$];

   int unsigned errors = 0;
   int unsigned req_gap = 0;
   int unsigned stall_left = 0;
   logic req_quiet = 1'b0;
   logic rsp_quiet = 1'b0;

   generational_handle_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_gen[i] = '0;
         slot_live[i] = 1'b0;
         slot_link[i] = '0;
      end
   end

   function automatic void drop_handle(logic [gha_pkg::INDEX_W-1:0] idx);
      for (int k = 0; k < live_handles.size(); k++) begin
         if (live_handles[k].idx == idx) begin
            live_handles.delete(k);
            return;
         end
      end
   endfunction

   function automatic gha_pkg::rsp_payload_type allocate_or_retire(
      gha_pkg::req_payload_type r);
      gha_pkg::rsp_payload_type o;
      logic [gha_pkg::COUNT_W-1:0] slot;
      logic [gha_pkg::GEN_W-1:0] g;
      logic hit;
      handle_type h;
      o = '0;
      o.status = gha_pkg::ST_STALE;
      hit = slot_live[r.slot_index] && slot_gen[r.slot_index] == r.slot_generation;
      case (r.req_type)
         gha_pkg::REQ_ALLOC: begin
            slot = LIST_END;
            if (soft_cap != '0 && live_total >= soft_cap) begin
               o.status = gha_pkg::ST_CAP;
            end else if (free_head != LIST_END) begin
               slot = free_head;
               free_head = slot_link[slot[gha_pkg::INDEX_W-1:0]];
            end else if (used_slots != LIST_END) begin
               slot = used_slots;
               used_slots = used_slots + 1'b1;
            end else begin
               o.status = gha_pkg::ST_FULL;
            end
            if (slot != LIST_END) begin
               if (slot_gen[slot[gha_pkg::INDEX_W-1:0]] == '0) begin
                  slot_gen[slot[gha_pkg::INDEX_W-1:0]] = 16'd1;
               end
               slot_live[slot[gha_pkg::INDEX_W-1:0]] = 1'b1;
               live_total = live_total + 1'b1;
               o.status = gha_pkg::ST_OK;
               o.out_index = slot[gha_pkg::INDEX_W-1:0];
               o.out_generation = slot_gen[slot[gha_pkg::INDEX_W-1:0]];
               h.idx = o.out_index;
               h.gen = o.out_generation;
               live_handles.push_back(h);
            end
         end
         gha_pkg::REQ_FREE: begin
            if (hit) begin
               g = slot_gen[r.slot_index] + 16'd1;
               if (g == '0) begin
                  g = 16'd1;
               end
               slot_gen[r.slot_index] = g;
               slot_live[r.slot_index] = 1'b0;
               slot_link[r.slot_index] = free_head;
               free_head = gha_pkg::COUNT_W'(r.slot_index);
               live_total = live_total - 1'b1;
               o.status = gha_pkg::ST_OK;
               drop_handle(r.slot_index);
            end
         end
         gha_pkg::REQ_VALIDATE: begin
            if (hit) begin
               o.status = gha_pkg::ST_OK;
            end
         end
         default: begin
            o.status = gha_pkg::ST_STALE;
         end
      endcase
      o.live_count = live_total;
      return o;
   endfunction

   function automatic int unsigned pick_delay();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(allocate_or_retire(req_data));
            if ($urandom_range(79) == 0) begin
               req_quiet <= !req_quiet;
            end
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap <= req_quiet ? 0 : pick_delay();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      gha_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("out_index", want.out_index, rsp_data.out_index);
               check_field("out_generation", want.out_generation, rsp_data.out_generation);
               check_field("live_count", want.live_count, rsp_data.live_count);
            end
            if ($urandom_range(79) == 0) begin
               rsp_quiet <= !rsp_quiet;
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= rsp_quiet ? 0 : pick_delay();
         end
      end
   end

   task automatic queue_request(input logic [gha_pkg::TYPE_W-1:0] kind,
                                input int unsigned idx, input int unsigned gen);
      gha_pkg::req_payload_type r;
      r.req_type = kind;
      r.slot_index = gha_pkg::INDEX_W'(idx);
      r.slot_generation = gha_pkg::GEN_W'(gen);
      pending_reqs.push_back(r);
   endtask

   function automatic gha_pkg::req_payload_type random_request();
      gha_pkg::req_payload_type r;
      handle_type h;
      int unsigned roll;
      roll = $urandom_range(99);
      r.req_type = ($urandom_range(1) == 0) ? gha_pkg::REQ_FREE : gha_pkg::REQ_VALIDATE;
      r.slot_index = gha_pkg::INDEX_W'($urandom);
      r.slot_generation = gha_pkg::GEN_W'($urandom);
      if (roll < 36) begin
         r.req_type = gha_pkg::REQ_ALLOC;
      end else if (roll < 88 && live_handles.size() != 0) begin
         h = live_handles[$urandom_range(live_handles.size() - 1)];
         r.req_type = (roll < 64) ? gha_pkg::REQ_FREE : gha_pkg::REQ_VALIDATE;
         r.slot_index = h.idx;
         r.slot_generation = h.gen;
         if ($urandom_range(9) == 0) begin
            r.slot_generation = h.gen ^ (16'd1 << $urandom_range(gha_pkg::GEN_W - 1));
         end
      end else if (roll >= 96) begin
         r.req_type = REQ_UNKNOWN;
      end
      return r;
   endfunction

   task automatic run_random(input int unsigned count);
      repeat (count) begin
         while (pending_reqs.size() >= 2) @(negedge clock);
         pending_reqs.push_back(random_request());
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cap(input logic [gha_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      soft_cap = value;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_request(gha_pkg::REQ_VALIDATE, 0, 0);
      queue_request(gha_pkg::REQ_FREE, 1023, 16'hFFFF);
      queue_request(REQ_UNKNOWN, 1023, 16'hFFFF);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_ALLOC, 1023, 16'hFFFF);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_VALIDATE, 1, 1);
      queue_request(gha_pkg::REQ_VALIDATE, 1, 2);
      queue_request(gha_pkg::REQ_FREE, 1, 1);
      queue_request(gha_pkg::REQ_FREE, 1, 1);
      queue_request(gha_pkg::REQ_VALIDATE, 1, 2);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_FREE, 0, 1);
      queue_request(gha_pkg::REQ_FREE, 2, 1);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      wait_idle();

      write_cap(11'd1);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_VALIDATE, 3, 1);
      wait_idle();

      write_cap(11'd4);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      queue_request(gha_pkg::REQ_FREE, 3, 1);
      queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      wait_idle();

      write_cap(11'd0);
      run_random(100);
      wait_idle();
      write_cap(11'd1);
      run_random(50);
      wait_idle();
      write_cap(11'd1024);
      run_random(80);
      wait_idle();
      write_cap(11'($urandom_range(8, 48)));
      run_random(100);
      wait_idle();
      write_cap(11'd2);
      run_random(40);
      wait_idle();

      // Fill every slot, then push a few more allocations into a full pool.
      write_cap(11'd0);
      repeat (SLOT_COUNT - live_total + 3) queue_request(gha_pkg::REQ_ALLOC, 0, 0);
      wait_idle();
      write_cap(11'd1024);
      run_random(150);
      wait_idle();
      write_cap(11'd1000);
      run_random(80);
      wait_idle();
      write_cap(11'd0);
      run_random(150);
      wait_idle();

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
hdl/gha_pkg.sv
hdl/generational_handle_allocator.sv
hdl/gha_checker.sv
sim/generational_handle_allocator_tb.sv
